[sv/spq_pkg.sv]
// Shared types and codes for the stable priority queue.
package spq_pkg;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_NOP     = 2'd3
  } spq_action_e;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

[sv/spq_if.sv]
// Request and result channel interfaces of the stable priority queue.
interface spq_in_if #(
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned DATA_BITS     = 32
);
  logic                     valid;
  logic                     ready;
  spq_pkg::spq_action_e     action;
  logic [PRIORITY_BITS-1:0] priority_req;
  logic [DATA_BITS-1:0]     data_handle;

  modport source (output valid, action, priority_req, data_handle, input ready);
  modport sink   (input valid, action, priority_req, data_handle, output ready);
endinterface

interface spq_out_if #(
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned DATA_BITS     = 32,
  parameter int unsigned COUNT_BITS    = 5
);
  logic                     valid;
  logic                     ready;
  logic [DATA_BITS-1:0]     head_data;
  logic                     head_valid;
  logic [PRIORITY_BITS-1:0] lowest_priority;
  logic                     is_empty;
  logic [COUNT_BITS-1:0]    entry_count;
  logic                     overflow;

  modport source (output valid, head_data, head_valid, lowest_priority, is_empty,
                  entry_count, overflow, input ready);
  modport sink   (input valid, head_data, head_valid, lowest_priority, is_empty,
                  entry_count, overflow, output ready);
endinterface

[sv/spq_cell.sv]
// One slot of the sorted shift row: holds an entry, compares, shifts.
module spq_cell #(
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned DATA_BITS     = 32
) (
  input  logic                     clk_i,
  input  spq_pkg::spq_ctrl_t       ctrl_i,
  input  logic                     valid_i,
  input  logic [PRIORITY_BITS-1:0] new_prio_i,
  input  logic [DATA_BITS-1:0]     new_data_i,
  input  logic                     left_keep_i,
  input  logic [PRIORITY_BITS-1:0] left_prio_i,
  input  logic [DATA_BITS-1:0]     left_data_i,
  input  logic [PRIORITY_BITS-1:0] right_prio_i,
  input  logic [DATA_BITS-1:0]     right_data_i,
  output logic                     keep_o,
  output logic [PRIORITY_BITS-1:0] prio_o,
  output logic [DATA_BITS-1:0]     data_o
);

  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic [DATA_BITS-1:0]     data_q, data_d;

  // Entry stays put on insert when it ties or beats the new one.
  assign keep_o = valid_i && (prio_q <= new_prio_i);

  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    if (ctrl_i.enq && !keep_o) begin
      if (left_keep_i) begin
        prio_d = new_prio_i;
        data_d = new_data_i;
      end else begin
        prio_d = left_prio_i;
        data_d = left_data_i;
      end
    end else if (ctrl_i.deq) begin
      prio_d = right_prio_i;
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign prio_o = prio_q;
  assign data_o = data_q;

endmodule

[sv/stable_priority_queue.sv]
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the whole row of
// cells updates together, and a stalled result holds off new requests.
// Reset: clears the entry count and the result valid flag; slot contents
// are not cleared and are never read before being written.
module stable_priority_queue #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned DATA_BITS     = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] FullCount = COUNT_BITS'(QUEUE_DEPTH);

  logic [COUNT_BITS-1:0]    count_q, count_d;
  logic                     in_fire;
  logic                     is_full, is_void;
  spq_pkg::spq_ctrl_t       ctrl;

  logic [PRIORITY_BITS-1:0] prio_w [QUEUE_DEPTH];
  logic [DATA_BITS-1:0]     data_w [QUEUE_DEPTH];
  logic                     keep_w [QUEUE_DEPTH];

  logic                     out_valid_q;
  logic [DATA_BITS-1:0]     head_data_q, head_data_d;
  logic                     head_valid_q, head_valid_d;
  logic [PRIORITY_BITS-1:0] lowest_q, lowest_d;
  logic                     overflow_q, overflow_d;
  logic [COUNT_BITS-1:0]    res_count_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_full    = (count_q == FullCount);
  assign is_void    = (count_q == '0);

  assign ctrl = '{
    enq: in_fire && (in_i.action == spq_pkg::ACT_ENQUEUE) && !is_full,
    deq: in_fire && (in_i.action == spq_pkg::ACT_DEQUEUE) && !is_void
  };

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                     left_keep;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;
    logic [DATA_BITS-1:0]     left_data, right_data;

    if (g == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_prio = '0;
      assign left_data = '0;
    end else begin : g_body
      assign left_keep = keep_w[g-1];
      assign left_prio = prio_w[g-1];
      assign left_data = data_w[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_prio = '0;
      assign right_data = '0;
    end else begin : g_inner
      assign right_prio = prio_w[g+1];
      assign right_data = data_w[g+1];
    end

    spq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .DATA_BITS     (DATA_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (count_q > COUNT_BITS'(g)),
      .new_prio_i   (in_i.priority_req),
      .new_data_i   (in_i.data_handle),
      .left_keep_i  (left_keep),
      .left_prio_i  (left_prio),
      .left_data_i  (left_data),
      .right_prio_i (right_prio),
      .right_data_i (right_data),
      .keep_o       (keep_w[g]),
      .prio_o       (prio_w[g]),
      .data_o       (data_w[g])
    );
  end

  always_comb begin
    count_d      = count_q;
    head_data_d  = '0;
    head_valid_d = 1'b0;
    overflow_d   = 1'b0;
    lowest_d     = prio_w[0];
    case (in_i.action)
      spq_pkg::ACT_ENQUEUE: begin
        if (is_full) begin
          overflow_d = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
          // New entry becomes head unless the current head ties or beats it.
          if (!keep_w[0]) begin
            lowest_d = in_i.priority_req;
          end
        end
      end
      spq_pkg::ACT_DEQUEUE: begin
        if (!is_void) begin
          head_data_d  = data_w[0];
          head_valid_d = 1'b1;
          count_d      = count_q - 1'b1;
          lowest_d     = prio_w[1];
        end
      end
      spq_pkg::ACT_PEEK: begin
        if (!is_void) begin
          head_data_d  = data_w[0];
          head_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (count_d == '0) begin
      lowest_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      head_data_q  <= head_data_d;
      head_valid_q <= head_valid_d;
      lowest_q     <= lowest_d;
      overflow_q   <= overflow_d;
      res_count_q  <= count_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.head_data       = head_data_q;
  assign out_o.head_valid      = head_valid_q;
  assign out_o.lowest_priority = lowest_q;
  assign out_o.is_empty        = (res_count_q == '0);
  assign out_o.entry_count     = res_count_q;
  assign out_o.overflow        = overflow_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count beyond queue depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.action == spq_pkg::ACT_ENQUEUE) && is_full
    |=> out_o.overflow && out_o.valid && (count_q == FullCount))
    else $error("enqueue into full queue not dropped");

  a_deq_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.action == spq_pkg::ACT_DEQUEUE) && !is_void
    |=> (count_q == $past(count_q) - 1'b1) && out_o.head_valid)
    else $error("dequeue did not remove the head");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.entry_count == count_q) && !(out_o.head_valid && out_o.overflow))
    else $error("result status disagrees with queue state");

endmodule

[verif/stable_priority_queue_tb.sv]
`timescale 1ns / 100ps
// Testbench for the stable priority queue: shadow-queue prediction, random traffic, stalls.
module stable_priority_queue_tb;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PRIO_W       = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TAIL_CYCLES  = 4;

  typedef struct packed {
    logic [DATA_W-1:0] head_data;
    logic              head_valid;
    logic [PRIO_W-1:0] lowest_priority;
    logic              is_empty;
    logic [CNT_W-1:0]  entry_count;
    logic              overflow;
  } head_status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  #(.PRIORITY_BITS(PRIO_W), .DATA_BITS(DATA_W)) req_if ();
  spq_out_if #(.PRIORITY_BITS(PRIO_W), .DATA_BITS(DATA_W), .COUNT_BITS(CNT_W)) rsp_if ();

  stable_priority_queue #(
    .QUEUE_DEPTH  (DEPTH),
    .PRIORITY_BITS(PRIO_W),
    .DATA_BITS    (DATA_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the sorted entries, head in slot 0.
  logic [PRIO_W-1:0] shadow_prio [DEPTH];
  logic [DATA_W-1:0] shadow_data [DEPTH];
  int unsigned       shadow_len;

  head_status_t pending_status[$];

  bit          send_idle_en;
  bit          sink_stall_en;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_enqueued;
  int unsigned n_dropped;
  int unsigned n_served;
  int unsigned n_empty_reads;
  int unsigned n_nops;

  // Apply one request to the shadow queue and queue up the status it yields.
  task automatic shadow_queue_step(spq_pkg::spq_action_e act, logic [PRIO_W-1:0] prio,
                                   logic [DATA_W-1:0] data);
    head_status_t st;
    int unsigned  pos;
    st = '0;
    case (act)
      spq_pkg::ACT_ENQUEUE: begin
        if (shadow_len >= DEPTH) begin
          st.overflow = 1'b1;
          n_dropped++;
        end else begin
          pos = 0;
          while (pos < shadow_len && shadow_prio[pos] <= prio) pos++;
          for (int i = shadow_len; i > pos; i--) begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_data[i] = shadow_data[i-1];
          end
          shadow_prio[pos] = prio;
          shadow_data[pos] = data;
          shadow_len++;
          n_enqueued++;
        end
      end
      spq_pkg::ACT_DEQUEUE, spq_pkg::ACT_PEEK: begin
        if (shadow_len > 0) begin
          st.head_data  = shadow_data[0];
          st.head_valid = 1'b1;
          n_served++;
          if (act == spq_pkg::ACT_DEQUEUE) begin
            for (int i = 0; i + 1 < shadow_len; i++) begin
              shadow_prio[i] = shadow_prio[i+1];
              shadow_data[i] = shadow_data[i+1];
            end
            shadow_len--;
          end
        end else begin
          n_empty_reads++;
        end
      end
      default: n_nops++;
    endcase
    st.lowest_priority = (shadow_len > 0) ? shadow_prio[0] : '0;
    st.is_empty        = (shadow_len == 0);
    st.entry_count     = CNT_W'(shadow_len);
    pending_status.push_back(st);
  endtask

  // Hold valid until the request is taken; optionally idle first.
  task automatic send_request(spq_pkg::spq_action_e act, logic [PRIO_W-1:0] prio,
                              logic [DATA_W-1:0] data);
    int unsigned gap;
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.priority_req <= prio;
    req_if.data_handle  <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    shadow_queue_step(act, prio, data);
    n_requests++;
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  function automatic spq_pkg::spq_action_e pick_action(int unsigned enq_pct,
                                                       int unsigned deq_pct,
                                                       int unsigned peek_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) return spq_pkg::ACT_ENQUEUE;
    if (roll < enq_pct + deq_pct) return spq_pkg::ACT_DEQUEUE;
    if (roll < enq_pct + deq_pct + peek_pct) return spq_pkg::ACT_PEEK;
    return spq_pkg::ACT_NOP;
  endfunction

  // Narrow ranges force ties; extremes hit the ends of the order.
  function automatic logic [PRIO_W-1:0] pick_prio(bit tie_heavy);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (tie_heavy || roll < 3) return PRIO_W'($urandom_range(0, 3));
    if (roll == 3) return '0;
    if (roll == 4) return '1;
    return PRIO_W'($urandom);
  endfunction

  task automatic run_mix(int unsigned n_items, int unsigned enq_pct, int unsigned deq_pct,
                         int unsigned peek_pct, bit tie_heavy);
    for (int i = 0; i < n_items; i++)
      send_request(pick_action(enq_pct, deq_pct, peek_pct), pick_prio(tie_heavy),
                   DATA_W'($urandom));
  endtask

  task automatic test_directed_corners();
    logic [PRIO_W-1:0] fill_prio [DEPTH];
    logic [DATA_W-1:0] data;
    fill_prio = '{16'hFFFF, 16'h0000, 16'd100, 16'd100, 16'h0000, 16'hFFFF, 16'd100, 16'd1,
                  16'h8000, 16'd100, 16'h0000, 16'hFFFE, 16'h7FFF, 16'd100, 16'hFFFF, 16'h0000};
    // Reads and a no-op on an empty queue.
    send_request(spq_pkg::ACT_DEQUEUE, '1, '1);
    send_request(spq_pkg::ACT_PEEK, '0, '0);
    send_request(spq_pkg::ACT_NOP, '1, '1);
    // Fill to the brim with repeated priorities so ties must stay in arrival order.
    for (int i = 0; i < DEPTH; i++) begin
      data = (i == 0) ? '0 : (i == 1) ? '1 : DATA_W'($urandom);
      send_request(spq_pkg::ACT_ENQUEUE, fill_prio[i], data);
    end
    send_request(spq_pkg::ACT_ENQUEUE, '0, '1);
    send_request(spq_pkg::ACT_PEEK, '0, '0);
    send_request(spq_pkg::ACT_NOP, '0, '0);
    send_request(spq_pkg::ACT_DEQUEUE, '0, '0);
    send_request(spq_pkg::ACT_DEQUEUE, '1, '1);
  endtask

  task automatic test_fill_heavy();
    run_mix(300, 70, 15, 10, 1'b0);
  endtask

  task automatic test_drain_heavy();
    run_mix(250, 25, 55, 15, 1'b0);
  endtask

  task automatic test_tie_order();
    run_mix(250, 50, 35, 10, 1'b1);
  endtask

  task automatic test_full_range();
    run_mix(300, 50, 35, 10, 1'b0);
  endtask

  task automatic test_back_to_back();
    send_idle_en  = 1'b0;
    sink_stall_en = 1'b0;
    run_mix(120, 60, 30, 8, 1'b0);
    run_mix(80, 30, 60, 8, 1'b1);
  endtask

  task automatic note_mismatch(string field, logic [63:0] exp_v, logic [63:0] got_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
    err_count++;
  endtask

  task automatic check_status();
    head_status_t exp_st;
    if (pending_status.size() == 0) begin
      $display("%0t: unexpected result, data %0h count %0d", $time, rsp_if.head_data,
               rsp_if.entry_count);
      err_count++;
      return;
    end
    exp_st = pending_status.pop_front();
    n_results++;
    if (rsp_if.head_data !== exp_st.head_data)
      note_mismatch("head_data", exp_st.head_data, rsp_if.head_data);
    if (rsp_if.head_valid !== exp_st.head_valid)
      note_mismatch("head_valid", exp_st.head_valid, rsp_if.head_valid);
    if (rsp_if.lowest_priority !== exp_st.lowest_priority)
      note_mismatch("lowest_priority", exp_st.lowest_priority, rsp_if.lowest_priority);
    if (rsp_if.is_empty !== exp_st.is_empty)
      note_mismatch("is_empty", exp_st.is_empty, rsp_if.is_empty);
    if (rsp_if.entry_count !== exp_st.entry_count)
      note_mismatch("entry_count", exp_st.entry_count, rsp_if.entry_count);
    if (rsp_if.overflow !== exp_st.overflow)
      note_mismatch("overflow", exp_st.overflow, rsp_if.overflow);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) check_status();
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_status.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: stall in bursts while stalls are enabled.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && sink_stall_en && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 16);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    req_if.valid        = 1'b0;
    req_if.action       = spq_pkg::ACT_NOP;
    req_if.priority_req = '0;
    req_if.data_handle  = '0;
    shadow_len          = 0;
    err_count           = 0;
    cycle_count         = 0;
    n_requests          = 0;
    n_results           = 0;
    n_enqueued          = 0;
    n_dropped           = 0;
    n_served            = 0;
    n_empty_reads       = 0;
    n_nops              = 0;
    send_idle_en        = 1'b1;
    sink_stall_en       = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    // Let everything come back before random traffic starts.
    wait_for_drain();
    test_fill_heavy();
    test_drain_heavy();
    test_tie_order();
    wait_for_drain();
    test_full_range();
    test_back_to_back();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d results: %0d stored, %0d dropped as full.",
             n_requests, n_results, n_enqueued, n_dropped);
    $display("Heads returned %0d times, empty reads %0d, no-ops %0d, mismatches %0d.",
             n_served, n_empty_reads, n_nops, err_count);
    if (err_count == 0 && pending_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
